// File: design/asfr_pkg.sv
// Shared types and constants for the appliance status frame receiver.
// No dependencies.
package asfr_pkg;

   localparam logic [7:0] START_BYTE       = 8'h81;
   localparam logic [7:0] NO_KETTLE_STATUS = 8'hFF;
   localparam logic [7:0] NO_WATER_TARGET  = 8'h64;
   localparam logic [7:0] NO_WATER_CURRENT = 8'h55;
   localparam logic [7:0] MODE_BYTE_OFF    = 8'h00;
   localparam logic [7:0] MODE_BYTE_HEAT   = 8'h01;

   localparam logic [7:0] CUR_BOIL_A = 8'h3B;
   localparam logic [7:0] CUR_BOIL_B = 8'h7B;
   localparam logic [7:0] CUR_WARM_A = 8'h63;
   localparam logic [7:0] CUR_WARM_B = 8'h3C;
   localparam logic [7:0] CUR_WARM_C = 8'h3D;

   localparam int SUM_W = 11;
   localparam int POS_W = 3;

   localparam logic [POS_W-1:0] POS_START    = 3'd0;
   localparam logic [POS_W-1:0] POS_STATUS   = 3'd1;
   localparam logic [POS_W-1:0] POS_MODE     = 3'd2;
   localparam logic [POS_W-1:0] POS_TARGET   = 3'd3;
   localparam logic [POS_W-1:0] POS_CURRENT  = 3'd4;
   localparam logic [POS_W-1:0] POS_PAD      = 3'd5;
   localparam logic [POS_W-1:0] POS_SUM_HIGH = 3'd6;
   localparam logic [POS_W-1:0] POS_SUM_LOW  = 3'd7;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_BOIL = 2'd1;
   localparam logic [1:0] MODE_WARM = 2'd2;
   localparam logic [1:0] MODE_TEA  = 2'd3;

   typedef struct packed {
      logic       valid;
      logic       sum_ok;
      logic [7:0] status;
      logic [7:0] mode;
      logic [7:0] target;
      logic [7:0] current;
   } frame_type;

endpackage

// File: design/asfr_collect.sv
// Byte collector: tracks frame position and running sum, holds a completed frame.
// Depends on asfr_pkg.
module asfr_collect (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   input  logic              frame_take,
   output asfr_pkg::frame_type frame
);
   import asfr_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [7:0]       status_ff, mode_ff, target_ff, current_ff, high_ff;
   frame_type        frame_ff, frame_in;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      frame_in = frame_ff;
      if (frame_take) begin
         frame_in.valid = 1'b0;
      end
      if (accept) begin
         case (pos_ff)
            POS_START: begin
               if (rx_byte == START_BYTE) begin
                  sum_in = SUM_W'(START_BYTE);
                  pos_in = POS_STATUS;
               end
            end
            POS_SUM_HIGH: pos_in = POS_SUM_LOW;
            POS_SUM_LOW: begin
               pos_in         = POS_START;
               frame_in.valid = 1'b1;
               frame_in.sum_ok = ({high_ff, rx_byte} == {5'd0, sum_ff});
               frame_in.status  = status_ff;
               frame_in.mode    = mode_ff;
               frame_in.target  = target_ff;
               frame_in.current = current_ff;
            end
            default: begin
               sum_in = sum_ff + SUM_W'(rx_byte);
               pos_in = pos_ff + 3'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_START;
         sum_ff   <= '0;
         frame_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (pos_ff)
            POS_STATUS:   status_ff  <= rx_byte;
            POS_MODE:     mode_ff    <= rx_byte;
            POS_TARGET:   target_ff  <= rx_byte;
            POS_CURRENT:  current_ff <= rx_byte;
            POS_SUM_HIGH: high_ff    <= rx_byte;
            default: ;
         endcase
      end
   end

   assign frame = frame_ff;

endmodule

// File: design/asfr_decode.sv
// Frame decoder and result register.
// Depends on asfr_pkg.
module asfr_decode (
   input  logic              clock,
   input  logic              reset,
   input  asfr_pkg::frame_type frame,
   input  logic              rsp_stall,
   output logic              frame_take,
   output logic              rsp_valid,
   output logic              rsp_checksum_error,
   output logic              rsp_no_kettle,
   output logic              rsp_no_water,
   output logic [1:0]        rsp_mode_class,
   output logic [7:0]        rsp_target_temp,
   output logic [7:0]        rsp_current_temp
);
   import asfr_pkg::*;

   logic       valid_ff, valid_in;
   logic       err_ff, err_in;
   logic       kettle_ff, kettle_in;
   logic       water_ff, water_in;
   logic [1:0] mode_ff, mode_in, heat_class;
   logic [7:0] target_ff, target_in, current_ff, current_in;

   assign frame_take = frame.valid && (!valid_ff || !rsp_stall);

   always_comb begin
      if (frame.current inside {CUR_BOIL_A, CUR_BOIL_B}) begin
         heat_class = MODE_BOIL;
      end else if (frame.current inside {CUR_WARM_A, CUR_WARM_B, CUR_WARM_C}) begin
         heat_class = MODE_WARM;
      end else begin
         heat_class = MODE_TEA;
      end

      err_in     = !frame.sum_ok;
      kettle_in  = 1'b0;
      water_in   = 1'b0;
      mode_in    = MODE_OFF;
      target_in  = '0;
      current_in = '0;
      if (frame.sum_ok) begin
         target_in  = frame.target;
         current_in = frame.current;
         if (frame.status == NO_KETTLE_STATUS) begin
            kettle_in = 1'b1;
            water_in  = (frame.target == NO_WATER_TARGET) &&
                        (frame.current == NO_WATER_CURRENT);
         end else begin
            case (frame.mode)
               MODE_BYTE_OFF:  mode_in = MODE_OFF;
               MODE_BYTE_HEAT: mode_in = heat_class;
               default:        mode_in = MODE_TEA;
            endcase
         end
      end

      valid_in = valid_ff && rsp_stall;
      if (frame_take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_take) begin
         err_ff     <= err_in;
         kettle_ff  <= kettle_in;
         water_ff   <= water_in;
         mode_ff    <= mode_in;
         target_ff  <= target_in;
         current_ff <= current_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_checksum_error = err_ff;
   assign rsp_no_kettle      = kettle_ff;
   assign rsp_no_water       = water_ff;
   assign rsp_mode_class     = mode_ff;
   assign rsp_target_temp    = target_ff;
   assign rsp_current_temp   = current_ff;

endmodule

// File: design/appliance_status_frame_receiver.sv
// Top level of the appliance status frame receiver: collector plus decoder.
// Depends on asfr_pkg, asfr_collect and asfr_decode.
//
//   channel  direction  payload                                    handshake
//   req      in         rx_byte                                    req_valid / req_stall
//   rsp      out        checksum_error, no_kettle, no_water,       rsp_valid / rsp_stall
//                       mode_class, target_temp, current_temp
//
// One byte per cycle while req_stall is low.
// A finished frame sits in the frame register, then the result register.
// req_stall rises only when both hold a result and rsp_stall is high.
// Synchronous reset clears the frame position and both valid flags.
module appliance_status_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_checksum_error,
   output logic       rsp_no_kettle,
   output logic       rsp_no_water,
   output logic [1:0] rsp_mode_class,
   output logic [7:0] rsp_target_temp,
   output logic [7:0] rsp_current_temp
);
   import asfr_pkg::*;

   frame_type frame;
   logic      frame_take;
   logic      accept;

   assign req_stall = frame.valid && !frame_take;
   assign accept    = req_valid && !req_stall;

   asfr_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .frame_take (frame_take),
      .frame      (frame)
   );

   asfr_decode u_decode (
      .clock              (clock),
      .reset              (reset),
      .frame              (frame),
      .rsp_stall          (rsp_stall),
      .frame_take         (frame_take),
      .rsp_valid          (rsp_valid),
      .rsp_checksum_error (rsp_checksum_error),
      .rsp_no_kettle      (rsp_no_kettle),
      .rsp_no_water       (rsp_no_water),
      .rsp_mode_class     (rsp_mode_class),
      .rsp_target_temp    (rsp_target_temp),
      .rsp_current_temp   (rsp_current_temp)
   );

endmodule
